// ===== sv/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

  // Command codes of an input word
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Fewest breakpoints that make a segment
  localparam logic [8:0] MIN_POINTS = 9'd2;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  // Saturation limits of a signed Q16.16 result
  localparam logic signed [31:0] Y_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Y_MIN = 32'sh8000_0000;

  // Register byte addresses (paddr[2] picks the register)
  localparam logic REG_POINTS_IN_USE = 1'b0;

  // Number of multiply-divide steps (one per bit of the slope magnitude)
  localparam int MD_STEPS = 33;

  // Classified word carried from front to back
  typedef struct packed {
    logic               cmd;
    logic               few;   // query with too few points in use
    logic [7:0]         idx;
    logic signed [31:0] x;
    logic [31:0]        y;
  } item_t;

endpackage

// ===== sv/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/pli_fifo.sv =====
// ----------------------------------------------------------------------------
// pli_fifo
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module pli_fifo
  import pli_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  empty
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW  = $clog2(QDEPTH + 1);

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign full  = (cnt_r == CW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

// ===== sv/pli_front.sv =====
// ----------------------------------------------------------------------------
// pli_front
// Accepts input words, drops loads to slots beyond the table and marks
// queries that have too few points to interpolate.
// ----------------------------------------------------------------------------
module pli_front
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic               push,
  output logic               full,
  input  logic               in_command,
  input  logic [7:0]         in_point_index,
  input  logic signed [31:0] in_x_value,
  input  logic signed [31:0] in_y_value,
  input  logic [8:0]         pts_in_use,
  input  logic               q_full,
  output logic               q_wr,
  output item_t              q_item,
  output logic [AW-1:0]      last_idx
);

  logic [31:0] cnt_ext;
  logic [31:0] n_sat;
  logic        slot_ok;

  // Clamp the point count to the table depth
  assign cnt_ext  = {23'd0, pts_in_use};
  assign n_sat    = (cnt_ext > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : cnt_ext;
  assign last_idx = AW'(n_sat - 32'd1);

  assign slot_ok = ({24'd0, in_point_index} < 32'(MAX_POINTS));

  assign full = q_full;

  always_comb begin
    q_item.cmd = in_command;
    q_item.few = (pts_in_use < MIN_POINTS);
    q_item.idx = in_point_index;
    q_item.x   = in_x_value;
    q_item.y   = in_y_value;
  end

  // Drop loads aimed past the table
  assign q_wr = push && !q_full && ((in_command == CMD_QUERY) || slot_ok);

endmodule

// ===== sv/pli_back.sv =====
// ----------------------------------------------------------------------------
// pli_back
// Executes queued words: writes breakpoints, scans segments for a query and
// runs a bit-serial multiply-divide for the interpolated value.
// ----------------------------------------------------------------------------
module pli_back
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  item_t              head,
  input  logic               head_vld,
  output logic               head_pop,
  input  logic [AW-1:0]      last_idx,
  output logic               tab_we,
  output logic [AW-1:0]      tab_waddr,
  output logic [AW-1:0]      tab_raddr,
  input  logic [31:0]        x_rdata,
  input  logic [31:0]        y_rdata,
  input  logic               res_free,
  output logic               res_we,
  output logic signed [31:0] res_y,
  output logic               res_nd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LAST = 7'b0000010,
    S_HEAD = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_MDIV = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } st_t;

  st_t                state_r, state_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic signed [31:0] px_r, px_nxt;
  logic signed [31:0] py_r, py_nxt;
  logic signed [31:0] y1_r, y1_nxt;
  logic [32:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [31:0]        t_r, t_nxt;
  logic [31:0]        den_r, den_nxt;
  logic [33:0]        q_r, q_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic signed [31:0] ry_r, ry_nxt;
  logic               rnd_r, rnd_nxt;

  logic signed [31:0] xd, yd;
  logic signed [32:0] dy;
  logic [33:0]        r2;
  logic [34:0]        e1, e2;
  logic signed [34:0] sum;

  assign xd = $signed(x_rdata);
  assign yd = $signed(y_rdata);
  assign dy = 33'(yd) - 33'(py_r);

  // One restoring step: take one slope bit, subtract the span up to twice
  assign r2 = {1'b0, rem_r, 1'b0} + (mag_r[32] ? {2'b00, t_r} : 34'd0);
  assign e1 = {1'b0, r2} - {3'b000, den_r};
  assign e2 = {1'b0, r2} - {2'b00, den_r, 1'b0};

  assign sum = neg_r ? (35'(y1_r) - $signed({1'b0, q_r}))
                     : (35'(y1_r) + $signed({1'b0, q_r}));

  assign tab_waddr = AW'({{AW{1'b0}}, head.idx});
  assign res_y     = ry_r;
  assign res_nd    = rnd_r;

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    idx_nxt   = idx_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    y1_nxt    = y1_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    t_nxt     = t_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    ry_nxt    = ry_r;
    rnd_nxt   = rnd_r;
    head_pop  = 1'b0;
    tab_we    = 1'b0;
    res_we    = 1'b0;
    tab_raddr = idx_r + 1'b1;

    case (state_r)
      S_IDLE: begin
        tab_raddr = last_idx;
        if (head_vld) begin
          head_pop = 1'b1;
          if (head.cmd == CMD_LOAD) begin
            tab_we = 1'b1;
          end else if (head.few) begin
            ry_nxt    = '0;
            rnd_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            x_nxt     = head.x;
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        tab_raddr = last_idx;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        tab_raddr = '0;
        idx_nxt   = '0;
        if (x_r > xd) begin
          ry_nxt    = '0;
          rnd_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r == '0) begin
          if (x_r < xd) begin
            ry_nxt    = '0;
            rnd_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            px_nxt  = xd;
            py_nxt  = yd;
            idx_nxt = idx_r + 1'b1;
          end
        end else if ((x_r >= px_r) && (x_r <= xd)) begin
          if (px_r == xd) begin
            ry_nxt    = '0;
            rnd_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            y1_nxt    = py_r;
            neg_nxt   = dy[32];
            mag_nxt   = dy[32] ? 33'(-dy) : 33'(dy);
            t_nxt     = 32'(33'(x_r) - 33'(px_r));
            den_nxt   = 32'(33'(xd) - 33'(px_r));
            q_nxt     = '0;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_MDIV;
          end
        end else if (idx_r == last_idx) begin
          ry_nxt    = '0;
          rnd_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          px_nxt  = xd;
          py_nxt  = yd;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_MDIV: begin
        mag_nxt = {mag_r[31:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (!e2[34]) begin
          rem_nxt = e2[31:0];
          q_nxt   = {q_r[32:0], 1'b0} + 34'd2;
        end else if (!e1[34]) begin
          rem_nxt = e1[31:0];
          q_nxt   = {q_r[32:0], 1'b0} + 34'd1;
        end else begin
          rem_nxt = r2[31:0];
          q_nxt   = {q_r[32:0], 1'b0};
        end
        if (cnt_r == 6'(MD_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Saturate the sum back to 32 bits
        if (sum > 35'(Y_MAX)) begin
          ry_nxt = Y_MAX;
        end else if (sum < 35'(Y_MIN)) begin
          ry_nxt = Y_MIN;
        end else begin
          ry_nxt = sum[31:0];
        end
        rnd_nxt   = 1'b0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_free) begin
          res_we    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    idx_r <= idx_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    y1_r  <= y1_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    t_r   <= t_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    ry_r  <= ry_nxt;
    rnd_r <= rnd_nxt;
  end

endmodule

// ===== sv/piecewise_linear_interp.sv =====
// Sequence: the back end writes a load into the table; a query fetches the last
//   and first points, scans the breakpoints one at a time from the table RAM
//   port, runs 33 bit-serial multiply-divide steps, then saturates and hands
//   off; with too few points a query goes straight to the hand-off as no data.
// Throughput: one word at a time in the back end; a 2-word queue lets the input
//   side keep taking words while a query runs. Reset clears control state only.
// ----------------------------------------------------------------------------
// piecewise_linear_interp
// Piecewise linear interpolation over a table of signed Q16.16 breakpoints,
// loaded one per word; queries return the interpolated y or a no-data flag.
// ----------------------------------------------------------------------------
module piecewise_linear_interp
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input queue side
  input  logic               push,
  output logic               full,
  input  logic               in_command,
  input  logic [7:0]         in_point_index,
  input  logic signed [31:0] in_x_value,
  input  logic signed [31:0] in_y_value,
  // Result queue side
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_y_result,
  output logic               out_no_data,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_POINTS);

  // Register file: points_in_use only
  logic [8:0] pts_r, pts_nxt;
  logic       cfg_wr;

  // Front to queue to back
  item_t         fq_item, qb_item;
  logic          fq_wr, q_full, q_empty, q_pop;
  logic [AW-1:0] last_idx;

  // Table RAM ports
  logic          tab_we;
  logic [AW-1:0] tab_waddr, tab_raddr;
  logic [31:0]   x_rdata, y_rdata;

  // Result register in front of the output queue side
  logic               ovld_r, ovld_nxt;
  logic signed [31:0] oy_r, oy_nxt;
  logic               ond_r, ond_nxt;
  logic               res_we, res_nd, res_free;
  logic signed [31:0] res_y;

  // Write the register on the access phase; paddr[2] selects it
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_POINTS_IN_USE);
  assign pts_nxt = cfg_wr ? pwdata[8:0] : pts_r;
  assign prdata  = (paddr[2] == REG_POINTS_IN_USE) ? {23'd0, pts_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= '0;
    end else begin
      pts_r <= pts_nxt;
    end
  end

  // Front end: accept and classify words
  pli_front #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_front (
    .push           (push),
    .full           (full),
    .in_command     (in_command),
    .in_point_index (in_point_index),
    .in_x_value     (in_x_value),
    .in_y_value     (in_y_value),
    .pts_in_use     (pts_r),
    .q_full         (q_full),
    .q_wr           (fq_wr),
    .q_item         (fq_item),
    .last_idx       (last_idx)
  );

  // Decouple front and back
  pli_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_wr),
    .wr_item (fq_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_item (qb_item),
    .empty   (q_empty)
  );

  // Breakpoint tables, written by loads, read by the scan
  pli_ram #(
    .W     (32),
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_x_tab (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (tab_waddr),
    .wdata   (qb_item.x),
    .raddr   (tab_raddr),
    .rd_data (x_rdata)
  );

  pli_ram #(
    .W     (32),
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_y_tab (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (tab_waddr),
    .wdata   (qb_item.y),
    .raddr   (tab_raddr),
    .rd_data (y_rdata)
  );

  // Back end: execute loads and queries in order
  pli_back #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (qb_item),
    .head_vld  (!q_empty),
    .head_pop  (q_pop),
    .last_idx  (last_idx),
    .tab_we    (tab_we),
    .tab_waddr (tab_waddr),
    .tab_raddr (tab_raddr),
    .x_rdata   (x_rdata),
    .y_rdata   (y_rdata),
    .res_free  (res_free),
    .res_we    (res_we),
    .res_y     (res_y),
    .res_nd    (res_nd)
  );

  // Hold a finished result until popped; take a new one in the same cycle
  assign res_free = !ovld_r || pop;

  always_comb begin
    ovld_nxt = ovld_r;
    oy_nxt   = oy_r;
    ond_nxt  = ond_r;
    if (pop && ovld_r) begin
      ovld_nxt = 1'b0;
    end
    if (res_we) begin
      ovld_nxt = 1'b1;
      oy_nxt   = res_y;
      ond_nxt  = res_nd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oy_r  <= oy_nxt;
    ond_r <= ond_nxt;
  end

  assign empty        = !ovld_r;
  assign out_y_result = oy_r;
  assign out_no_data  = ond_r;

endmodule

// ===== test/piecewise_linear_interp_test.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_interp_test
// Self-checking bench for the breakpoint interpolator. Words (loads and
// queries) stream in through the push/full side in random bursts. Answers
// drain through the empty/pop side under changing stall patterns. Each
// accepted query is predicted from a shadow breakpoint table and compared
// field by field with the answer that comes out. The point count is
// reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module piecewise_linear_interp_test
  import pli_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 256;
  // Leave margin after the last answer for the longest query
  localparam int DRAIN_CYCLES = 340;
  localparam int HOLD_CYCLES = 600;
  localparam int STUCK_LIMIT = 20000;
  localparam int TARGET_WORDS = 1550;

  localparam logic [2:0] ADDR_POINTS = {REG_POINTS_IN_USE, 2'b00};
  localparam logic [2:0] ADDR_SPARE = 3'h4;   // no register lives here

  localparam logic signed [31:0] X_LO = 32'sh8000_0000;
  localparam logic signed [31:0] X_HI = 32'sh7FFF_FFFF;

  typedef struct {
    logic               cmd;
    logic [7:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } word_t;

  typedef struct {
    logic signed [31:0] y;
    logic               nd;
  } answer_t;

  typedef enum logic [1:0] {RX_STREAM, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               in_command = CMD_LOAD;
  logic [7:0]         in_point_index = '0;
  logic signed [31:0] in_x_value = '0;
  logic signed [31:0] in_y_value = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] out_y_result;
  logic               out_no_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow of the block: breakpoint table and point count, updated on acceptance
  logic signed [31:0] bp_x [DEPTH];
  logic signed [31:0] bp_y [DEPTH];
  logic [8:0]         points_cfg = '0;

  // Stimulus-side view of the table, updated as words are queued
  logic signed [31:0] gen_x [DEPTH];
  bit                 gen_written [DEPTH];

  word_t   word_q[$];
  answer_t answer_q[$];
  int      words_queued = 0;
  int      words_taken = 0;
  int      results_seen = 0;
  int      errors = 0;

  piecewise_linear_interp #(.MAX_POINTS(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_command(in_command), .in_point_index(in_point_index),
    .in_x_value(in_x_value), .in_y_value(in_y_value),
    .empty(empty), .pop(pop),
    .out_y_result(out_y_result), .out_no_data(out_no_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict one query: scan from the first segment, take the first that
  // encloses x, then y1 + trunc(dy * (x - x1) / (x2 - x1)) at full width.
  function automatic answer_t interpolate(logic signed [31:0] xq);
    answer_t            a;
    int                 n;
    int                 i;
    bit                 hit;
    bit                 neg;
    logic signed [63:0] xe, x1, x2, y1, y2, dy, r;
    logic [127:0]       mag, t, den, q;
    a.y = '0;
    a.nd = 1'b1;
    hit = 1'b0;
    xe = xq;
    // Counts above the table depth saturate to the depth
    n = (points_cfg > DEPTH) ? DEPTH : int'(points_cfg);
    // Too few points, or x outside the first and last breakpoint: no data
    if (n < int'(MIN_POINTS) || xq < bp_x[0] || xq > bp_x[n-1]) return a;
    for (i = 1; i < n && !hit; i++) begin
      x1 = bp_x[i-1];
      x2 = bp_x[i];
      if (xe >= x1 && xe <= x2) begin
        hit = 1'b1;
        // A degenerate first enclosing segment ends the scan with no data
        if (x1 != x2) begin
          y1 = bp_y[i-1];
          y2 = bp_y[i];
          dy = y2 - y1;
          neg = dy < 0;
          mag = {64'd0, neg ? -dy : dy};
          t = {64'd0, xe - x1};
          den = {64'd0, x2 - x1};
          q = (mag * t) / den;
          r = neg ? y1 - $signed(q[63:0]) : y1 + $signed(q[63:0]);
          if (r > 64'(Y_MAX)) r = 64'(Y_MAX);
          if (r < 64'(Y_MIN)) r = 64'(Y_MIN);
          a.y = r[31:0];
          a.nd = 1'b0;
        end
      end
    end
    return a;
  endfunction

  function automatic longint unsigned rand_below(longint unsigned m);
    return {$urandom, $urandom} % m;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued words in bursts of random length, with random gaps.
  // A word stays on the ports until taken; only then advance to the next.
  // ---------------------------------------------------------------------------
  word_t cur;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        // Word accepted: update the shadow table or predict the answer
        if (cur.cmd == CMD_LOAD) begin
          bp_x[cur.idx] = cur.x;
          bp_y[cur.idx] = cur.y;
        end else begin
          answer_q.push_back(interpolate(cur.x));
        end
        words_taken++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (word_q.size() > 0) begin
          cur = word_q.pop_front();
          push <= 1'b1;
          in_command <= cur.cmd;
          in_point_index <= cur.idx;
          in_x_value <= cur.x;
          in_y_value <= cur.y;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Close the burst: pick the next burst length and the gap before it
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              9:          gap_left = $urandom_range(20, 40);
              default:    gap_left = $urandom_range(1, 6);
            endcase
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take answers under a stall pattern that changes at random, and
  // check each against the oldest prediction. Twice, while the sender still
  // has plenty queued, hold pop low for a long stretch to back the block up
  // and stall its input.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_STREAM;
  int       mode_left = 0;
  int       hold_left = 0;
  int       holds_done = 0;
  answer_t  want;

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      mode_left = 0;
      hold_left = 0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected answer y_result %0d no_data %0b",
                   $time, out_y_result, out_no_data);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (out_y_result !== want.y) begin
            $display("%0t: y_result expected %0d, got %0d", $time, want.y, out_y_result);
            errors++;
          end
          if (out_no_data !== want.nd) begin
            $display("%0t: no_data expected %0b, got %0b", $time, want.nd, out_no_data);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (holds_done < 2 && results_seen >= 150 + 500 * holds_done &&
                   word_q.size() > 20) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STREAM: pop <= 1'b1;
          RX_HALF:   pop <= 1'($urandom_range(0, 1));
          RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
          default:   pop <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Watchdog: end the run if neither side moves a word for too long
  int stuck = 0;

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One register transfer: setup cycle, then access until pready
  task automatic cfg_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr == ADDR_POINTS) points_cfg = wdata[8:0];
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every queued word is taken and every answer is back, then
  // let the back end finish any trailing load
  task automatic settle();
    while (words_taken != words_queued || answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_points(input int value);
    logic [31:0] rd;
    settle();
    cfg_access(1'b1, ADDR_POINTS, 32'(value), rd);
    cfg_access(1'b0, ADDR_POINTS, '0, rd);
    if (rd !== {23'd0, points_cfg}) begin
      $display("%0t: points_in_use read expected %0d, got %0d", $time, points_cfg, rd);
      errors++;
    end
  endtask

  task automatic add_word(input logic cmd, input logic [7:0] idx,
                          input logic signed [31:0] x, input logic signed [31:0] y);
    word_t w;
    w.cmd = cmd;
    w.idx = idx;
    w.x = x;
    w.y = y;
    word_q.push_back(w);
    words_queued++;
    if (cmd == CMD_LOAD) begin
      gen_x[idx] = x;
      gen_written[idx] = 1'b1;
    end
  endtask

  // Load slots 0..n-1: mostly ascending x with random spacing (zero steps
  // make degenerate segments), sometimes scrambled x; y random or smooth
  task automatic build_table(input int n);
    longint span, stepmax, pos, ypos;
    int     sb;
    bit     sorted, smooth;
    sorted = ($urandom_range(0, 5) != 0);
    smooth = 1'($urandom_range(0, 1));
    sb = $urandom_range(3, 32);
    span = longint'(1) << sb;
    stepmax = span / n;
    if (stepmax < 1) stepmax = 1;
    pos = longint'(X_LO) + longint'(rand_below((longint'(1) << 32) - span + 1));
    ypos = longint'(int'($urandom));
    for (int i = 0; i < n; i++) begin
      add_word(CMD_LOAD, 8'(i), sorted ? 32'(pos) : 32'($urandom),
               smooth ? 32'(ypos) : 32'($urandom));
      if ($urandom_range(0, 7) != 0) pos += 1 + longint'(rand_below(stepmax));
      if (pos > longint'(X_HI)) pos = longint'(X_HI);
      ypos += longint'(int'($urandom)) >>> $urandom_range(4, 30);
      if (ypos > longint'(X_HI)) ypos = longint'(X_HI);
      if (ypos < longint'(X_LO)) ypos = longint'(X_LO);
    end
  endtask

  // One phase: program the count, make sure every slot a query can read is
  // loaded, then mix queries (mostly inside the table) with stray loads
  task automatic run_phase(input int count, input int mix);
    int     n, i;
    bit     need;
    longint lo, hi, sw;
    logic signed [31:0] xq;
    n = (count > DEPTH) ? DEPTH : count;
    set_points(count);
    need = 1'b0;
    for (i = 0; i < n; i++) if (!gen_written[i]) need = 1'b1;
    if (n >= 2 && (need || (n <= 40 && $urandom_range(0, 2) == 0))) build_table(n);
    for (int k = 0; k < mix; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        // Stray load: mostly beyond the slots in use, sometimes over one
        if (n < DEPTH && $urandom_range(0, 2) != 0) i = $urandom_range(n, DEPTH - 1);
        else i = $urandom_range(0, DEPTH - 1);
        add_word(CMD_LOAD, 8'(i), 32'($urandom), 32'($urandom));
      end else begin
        if (n < 2) begin
          xq = 32'($urandom);
        end else begin
          case ($urandom_range(0, 9))
            0: xq = 32'($urandom);
            1: xq = (gen_x[0] == X_LO) ? gen_x[0] : gen_x[0] - 1;
            2: xq = (gen_x[n-1] == X_HI) ? gen_x[n-1] : gen_x[n-1] + 1;
            3: xq = gen_x[$urandom_range(0, n - 1)];
            4: xq = $urandom_range(0, 1) ? X_HI : X_LO;
            default: begin
              i = $urandom_range(1, n - 1);
              lo = gen_x[i-1];
              hi = gen_x[i];
              if (lo > hi) begin
                sw = lo;
                lo = hi;
                hi = sw;
              end
              xq = 32'(lo + longint'(rand_below(hi - lo + 1)));
            end
          endcase
        end
        add_word(CMD_QUERY, 8'($urandom), xq, 32'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] rd;
    int          pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // No points in use: a query has no data
    set_points(0);
    add_word(CMD_LOAD, 8'd0, X_LO, X_HI);
    add_word(CMD_LOAD, 8'd1, X_HI, X_LO);
    add_word(CMD_QUERY, 8'd0, 32'sd0, 32'sd0);

    // One point is still too few
    set_points(1);
    add_word(CMD_QUERY, 8'hFF, 32'sd0, X_HI);

    // Full-range segment with the steepest falling slope
    set_points(2);
    add_word(CMD_QUERY, 8'd0, X_LO, 32'sd0);
    add_word(CMD_QUERY, 8'd0, X_HI, 32'sd0);
    add_word(CMD_QUERY, 8'd0, 32'sd0, 32'sd0);
    add_word(CMD_QUERY, 8'd0, 32'sd1, 32'sd0);
    add_word(CMD_QUERY, 8'd0, -32'sd1, 32'sd0);

    // A write past the last register must leave the count alone
    settle();
    cfg_access(1'b1, ADDR_SPARE, $urandom, rd);
    add_word(CMD_QUERY, 8'd0, 32'sd12345, 32'sd0);

    // Degenerate first segment at x = -100, then out of range on both sides
    add_word(CMD_LOAD, 8'd0, -32'sd100, 32'sd7);
    add_word(CMD_LOAD, 8'd1, -32'sd100, 32'sd9);
    add_word(CMD_LOAD, 8'd2, 32'sd100, -32'sd3);
    set_points(3);
    add_word(CMD_QUERY, 8'd0, -32'sd100, 32'sd0);
    add_word(CMD_QUERY, 8'd0, -32'sd101, 32'sd0);
    add_word(CMD_QUERY, 8'd0, 32'sd101, 32'sd0);
    add_word(CMD_QUERY, 8'd0, 32'sd50, 32'sd0);
    add_word(CMD_QUERY, 8'd0, 32'sd100, 32'sd0);

    // Unsorted table: middle point past the last one
    add_word(CMD_LOAD, 8'd1, 32'sd200, 32'sd5);
    add_word(CMD_QUERY, 8'd0, 32'sd150, 32'sd0);
    add_word(CMD_QUERY, 8'd0, 32'sd100, 32'sd0);

    // Count extremes first: all bits set (saturates) and the full depth
    run_phase(511, 15);
    run_phase(DEPTH, 15);

    // Random phases, mostly short tables to keep queries quick
    while (words_queued < TARGET_WORDS) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0:       run_phase(0, $urandom_range(10, 30));
        1:       run_phase(1, $urandom_range(10, 30));
        2:       run_phase(2, $urandom_range(30, 110));
        13, 14:  run_phase($urandom_range(13, 40), $urandom_range(30, 80));
        15:      run_phase($urandom_range(64, 200), 12);
        16:      run_phase(DEPTH, 10);
        17:      run_phase($urandom_range(DEPTH + 1, 511), 10);
        default: run_phase($urandom_range(2, 12), $urandom_range(30, 110));
      endcase
    end

    settle();
    if (answer_q.size() != 0) begin
      $display("%0t: %0d answers never arrived", $time, answer_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
